// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the SATA DMA command builder.
// Needs a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define SDCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SDCB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/sdcb_pkg.sv =====
// Package of the SATA DMA command builder: widths, opcodes, result kinds,
// request and decoded-job types. No dependencies.
package sdcb_pkg;

    localparam int CHUNK_BYTES  = 4194304;
    localparam int SECTOR_BYTES = 512;

    localparam int LBA_W   = 48;
    localparam int COUNT_W = 16;
    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 22;
    localparam int ENTRY_W = 4;
    localparam int OP_W    = 8;

    localparam int MAX_ENTRIES  = 8;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int CHUNK_SHIFT  = $clog2(CHUNK_BYTES);
    localparam int BYTES_W      = COUNT_W + SECTOR_SHIFT;
    localparam int ENT_FULL_W   = BYTES_W - CHUNK_SHIFT + 1;

    localparam logic [OP_W-1:0] OP_READ_DMA_EXT  = 8'h25;
    localparam logic [OP_W-1:0] OP_WRITE_DMA_EXT = 8'h35;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        logic               is_write;
        logic [LBA_W-1:0]   lba;
        logic [COUNT_W-1:0] sector_count;
        logic [ADDR_W-1:0]  buffer_address;
    } t_req;

    typedef struct packed {
        logic               reject;
        logic               is_write;
        logic [LBA_W-1:0]   lba;
        logic [COUNT_W-1:0] count;
        logic [ENTRY_W-1:0] entries;
        logic [LEN_W-1:0]   last_len_m1;
        logic [ADDR_W-1:0]  buffer_address;
    } t_job;

endpackage

// ===== sv/sata_dma_command_builder.sv =====
// SATA DMA command builder: one request in, a command word plus up to eight
// scatter-gather entry words out (or one reject word).
// Path: input register, decode into the job register, then the output register.
// Throughput: one output word per cycle while i_stall is low; a request emits
// entries + 1 words, one for a reject, set by the single output register.
// Reset (synchronous, active low) empties all stages and clears max_lba to 0.
module sata_dma_command_builder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_max_lba_we,
    input  logic [sdcb_pkg::LBA_W-1:0]     i_max_lba,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_is_write,
    input  logic [sdcb_pkg::LBA_W-1:0]     i_lba,
    input  logic [sdcb_pkg::COUNT_W-1:0]   i_sector_count,
    input  logic [sdcb_pkg::ADDR_W-1:0]    i_buffer_address,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_kind,
    output logic [sdcb_pkg::OP_W-1:0]      o_ata_command,
    output logic [sdcb_pkg::LBA_W-1:0]     o_device_lba,
    output logic [sdcb_pkg::COUNT_W-1:0]   o_fis_count,
    output logic [sdcb_pkg::ENTRY_W-1:0]   o_entry_count,
    output logic                           o_write_direction,
    output logic [sdcb_pkg::ADDR_W-1:0]    o_entry_address,
    output logic [sdcb_pkg::LEN_W-1:0]     o_entry_length_minus_one,
    output logic                           o_entry_interrupt,
    output logic                           o_last
);

`include "assert_macros.svh"

    logic [sdcb_pkg::LBA_W-1:0]   r_max_lba;

    logic                         r_in_valid;
    sdcb_pkg::t_req               r_in;
    sdcb_pkg::t_job               dec_job;

    logic                         r_job_valid;
    sdcb_pkg::t_job               r_job;
    logic [sdcb_pkg::ENTRY_W-1:0] r_idx;
    logic [sdcb_pkg::ADDR_W-1:0]  r_addr;
    logic [sdcb_pkg::ENTRY_W-1:0] n_idx;
    logic [sdcb_pkg::ADDR_W-1:0]  n_addr;

    logic                         r_o_valid;
    sdcb_pkg::t_kind              r_o_kind;
    logic [sdcb_pkg::OP_W-1:0]    r_o_cmd;
    logic [sdcb_pkg::LBA_W-1:0]   r_o_lba;
    logic [sdcb_pkg::COUNT_W-1:0] r_o_count;
    logic [sdcb_pkg::ENTRY_W-1:0] r_o_entries;
    logic                         r_o_wr;
    logic [sdcb_pkg::ADDR_W-1:0]  r_o_addr;
    logic [sdcb_pkg::LEN_W-1:0]   r_o_len;
    logic                         r_o_irq;
    logic                         r_o_last;

    sdcb_pkg::t_kind              n_o_kind;
    logic [sdcb_pkg::OP_W-1:0]    n_o_cmd;
    logic [sdcb_pkg::LBA_W-1:0]   n_o_lba;
    logic [sdcb_pkg::COUNT_W-1:0] n_o_count;
    logic [sdcb_pkg::ENTRY_W-1:0] n_o_entries;
    logic                         n_o_wr;
    logic [sdcb_pkg::ADDR_W-1:0]  n_o_addr;
    logic [sdcb_pkg::LEN_W-1:0]   n_o_len;
    logic                         n_o_irq;
    logic                         n_o_last;

    logic                         out_free;
    logic                         emit;
    logic                         job_done;
    logic                         job_load;
    logic                         in_accept;

    sdcb_decode u_decode (
        .i_req     (r_in),
        .i_max_lba (r_max_lba),
        .o_job     (dec_job)
    );

    assign out_free  = !r_o_valid || !i_stall;
    assign emit      = r_job_valid && out_free;
    assign job_done  = emit && n_o_last;
    assign job_load  = !r_job_valid || job_done;
    assign o_stall   = r_in_valid && !job_load;
    assign in_accept = i_valid && !o_stall;

    // next output word from the job in hand
    always_comb begin
        n_o_kind    = sdcb_pkg::KIND_REJECT;
        n_o_cmd     = '0;
        n_o_lba     = '0;
        n_o_count   = '0;
        n_o_entries = '0;
        n_o_wr      = 1'b0;
        n_o_addr    = '0;
        n_o_len     = '0;
        n_o_irq     = 1'b0;
        n_o_last    = 1'b1;
        n_idx       = r_idx;
        n_addr      = r_addr;
        if (r_job.reject) begin
            n_o_kind = sdcb_pkg::KIND_REJECT;
        end else if (r_idx == '0) begin
            n_o_kind    = sdcb_pkg::KIND_CMD;
            n_o_cmd     = r_job.is_write ? sdcb_pkg::OP_WRITE_DMA_EXT
                                         : sdcb_pkg::OP_READ_DMA_EXT;
            n_o_lba     = r_job.lba;
            n_o_count   = r_job.count;
            n_o_entries = r_job.entries;
            n_o_wr      = r_job.is_write;
            n_o_last    = 1'b0;
            n_idx       = r_idx + sdcb_pkg::ENTRY_W'(1);
        end else begin
            n_o_kind = sdcb_pkg::KIND_ENTRY;
            n_o_addr = r_addr;
            n_o_irq  = 1'b1;
            n_o_last = (r_idx == r_job.entries);
            n_o_len  = n_o_last ? r_job.last_len_m1
                                : sdcb_pkg::LEN_W'(sdcb_pkg::CHUNK_BYTES - 1);
            n_idx    = r_idx + sdcb_pkg::ENTRY_W'(1);
            n_addr   = r_addr + sdcb_pkg::ADDR_W'(sdcb_pkg::CHUNK_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lba <= '0;
        end else if (i_max_lba_we) begin
            r_max_lba <= i_max_lba;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (job_load) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in.is_write       <= i_is_write;
            r_in.lba            <= i_lba;
            r_in.sector_count   <= i_sector_count;
            r_in.buffer_address <= i_buffer_address;
        end
    end

    // job register and word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (job_load) begin
            r_job_valid <= r_in_valid;
            r_idx       <= '0;
        end else if (emit) begin
            r_idx       <= n_idx;
        end
        if (job_load) begin
            r_job  <= dec_job;
            r_addr <= dec_job.buffer_address;
        end else if (emit) begin
            r_addr <= n_addr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_job_valid;
        end
        if (emit) begin
            r_o_kind    <= n_o_kind;
            r_o_cmd     <= n_o_cmd;
            r_o_lba     <= n_o_lba;
            r_o_count   <= n_o_count;
            r_o_entries <= n_o_entries;
            r_o_wr      <= n_o_wr;
            r_o_addr    <= n_o_addr;
            r_o_len     <= n_o_len;
            r_o_irq     <= n_o_irq;
            r_o_last    <= n_o_last;
        end
    end

    assign o_valid                  = r_o_valid;
    assign o_kind                   = r_o_kind;
    assign o_ata_command            = r_o_cmd;
    assign o_device_lba             = r_o_lba;
    assign o_fis_count              = r_o_count;
    assign o_entry_count            = r_o_entries;
    assign o_write_direction        = r_o_wr;
    assign o_entry_address          = r_o_addr;
    assign o_entry_length_minus_one = r_o_len;
    assign o_entry_interrupt        = r_o_irq;
    assign o_last                   = r_o_last;

    `SDCB_ASSERT(a_idx_in_range, (r_job_valid && !r_job.reject) |-> (r_idx <= r_job.entries), "word index beyond entry count")
    `SDCB_ASSERT(a_burst_unbroken, (r_o_valid && !i_stall && !r_o_last) |=> r_o_valid, "gap inside a request's words")
    `SDCB_ASSERT(a_cmd_entries, (r_o_valid && r_o_kind == sdcb_pkg::KIND_CMD) |-> (r_o_entries != '0 && r_o_entries <= sdcb_pkg::ENTRY_W'(sdcb_pkg::MAX_ENTRIES) && !r_o_last), "bad command word")
    `SDCB_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_o_valid && !r_job_valid && !r_in_valid), "stages not empty after reset")

endmodule

// ===== sv/sdcb_decode.sv =====
// Request decode: range check against max_lba, clamping, entry count and
// the length of the final chunk. Depends on sdcb_pkg.
module sdcb_decode (
    input  sdcb_pkg::t_req               i_req,
    input  logic [sdcb_pkg::LBA_W-1:0]   i_max_lba,
    output sdcb_pkg::t_job               o_job
);

    logic                                 past_end;
    logic [sdcb_pkg::LBA_W:0]             end_sum;
    logic                                 over_end;
    logic [sdcb_pkg::LBA_W-1:0]           room;
    logic [sdcb_pkg::COUNT_W-1:0]         count_c;
    logic [sdcb_pkg::BYTES_W-1:0]         bytes;
    logic [sdcb_pkg::ENT_FULL_W-1:0]      ent_full;
    logic [sdcb_pkg::CHUNK_SHIFT-1:0]     rem_m1;
    logic                                 too_many;

    always_comb begin
        past_end = i_req.lba >= i_max_lba;
        end_sum  = {1'b0, i_req.lba}
                 + {{(sdcb_pkg::LBA_W + 1 - sdcb_pkg::COUNT_W){1'b0}}, i_req.sector_count};
        over_end = end_sum > {1'b0, i_max_lba};
        room     = i_max_lba - i_req.lba;
        // reads that cross the end stop at max_lba; room < count there
        count_c  = (!i_req.is_write && over_end) ? room[sdcb_pkg::COUNT_W-1:0]
                                                  : i_req.sector_count;

        bytes    = {count_c, {sdcb_pkg::SECTOR_SHIFT{1'b0}}};
        ent_full = sdcb_pkg::ENT_FULL_W'(bytes[sdcb_pkg::BYTES_W-1:sdcb_pkg::CHUNK_SHIFT])
                 + sdcb_pkg::ENT_FULL_W'(|bytes[sdcb_pkg::CHUNK_SHIFT-1:0]);
        too_many = ent_full > sdcb_pkg::ENT_FULL_W'(sdcb_pkg::MAX_ENTRIES);
        // a zero remainder wraps to a full chunk minus one
        rem_m1   = bytes[sdcb_pkg::CHUNK_SHIFT-1:0] - sdcb_pkg::CHUNK_SHIFT'(1);

        o_job.reject         = (!i_req.is_write && past_end) || (count_c == '0) || too_many;
        o_job.is_write       = i_req.is_write;
        o_job.lba            = i_req.lba;
        o_job.count          = count_c;
        o_job.entries        = sdcb_pkg::ENTRY_W'(ent_full);
        o_job.last_len_m1    = sdcb_pkg::LEN_W'(rem_m1);
        o_job.buffer_address = i_req.buffer_address;
    end

endmodule
